FILE: rtl/core/mlr_pkg.sv
// Package for the midpoint line rasterizer: payload types, line modes, shared helper.
`default_nettype none
package mlr_pkg;

    localparam int COORD_BITS = 10;
    // Signed width of the decision term and of the widened deltas.
    localparam int DEC_W      = COORD_BITS + 4;

    typedef logic [COORD_BITS-1:0] coord_t;
    typedef logic signed [DEC_W-1:0] dec_t;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_STEP = 1'b1;

    typedef enum logic [2:0] {
        MODE_VERT       = 3'd0,
        MODE_HORIZ      = 3'd1,
        MODE_DIAG_POS   = 3'd2,
        MODE_DIAG_NEG   = 3'd3,
        MODE_SHALLOW_POS = 3'd4,
        MODE_STEEP_POS  = 3'd5,
        MODE_SHALLOW_NEG = 3'd6,
        MODE_STEEP_NEG  = 3'd7
    } mode_t;

    typedef struct packed {
        logic   command;
        coord_t start_x;
        coord_t start_y;
        coord_t end_x;
        coord_t end_y;
    } mlr_in_t;

    typedef struct packed {
        coord_t pixel_x;
        coord_t pixel_y;
        logic   pixel_valid;
        logic   last_pixel;
    } mlr_out_t;

    // Walker state; delta_x is never negative, delta_y is signed.
    typedef struct packed {
        coord_t                      cur_x;
        coord_t                      cur_y;
        coord_t                      stop_x;
        coord_t                      stop_y;
        logic [COORD_BITS-1:0]       delta_x;
        logic signed [COORD_BITS:0]  delta_y;
        dec_t                        decision;
        mode_t                       mode;
        logic                        active;
    } mlr_state_t;

    // Steep and vertical lines finish on y, all others on x.
    function automatic logic at_end(input mlr_state_t st);
        logic y_major;
        y_major = (st.mode == MODE_VERT) || (st.mode == MODE_STEEP_POS)
               || (st.mode == MODE_STEEP_NEG);
        return y_major ? (st.cur_y == st.stop_y) : (st.cur_x == st.stop_x);
    endfunction

endpackage
`default_nettype wire

FILE: rtl/core/midpoint_line_rasterizer_top.sv
// Top level of the midpoint line rasterizer: beat registers, walker state, result mux.
`default_nettype none
// Midpoint line rasterizer. Every input beat yields exactly one result beat.
// A load beat (command 0) takes two endpoints, orders them by x (by y when
// x is equal), picks one of eight line modes and returns the start pixel;
// a single-point line comes back with last_pixel set and leaves nothing
// active. A step beat (command 1) returns the next pixel of the line and
// flags the final endpoint with last_pixel; a step with no active line
// returns pixel_valid = 0 with zero coordinates. A load always drops any
// line in progress. Throughput is one beat per clock unless m_ready holds
// the result back: the input register feeds one pass of setup/step logic
// into the result register, so each result is offered from the result
// register once its beat has passed through the input register. The input
// register can still take one beat while a finished result waits for
// m_ready; the input side stalls only when both registers are full.
module midpoint_line_rasterizer_top
    import mlr_pkg::*;
(
    input  wire          aclk,
    input  wire          aresetn,
    input  wire          s_valid,
    output logic         s_ready,
    input  wire mlr_in_t s_payload,
    output logic         m_valid,
    input  wire          m_ready,
    output mlr_out_t     m_payload
);

    // Input register
    logic       in_valid_reg, in_valid_next;
    mlr_in_t    in_data_reg;

    // Walker state
    mlr_state_t state_reg, state_next;

    // Result register
    logic       m_valid_reg, m_valid_next;
    mlr_out_t   out_data_reg, out_data_next;

    logic       out_free;
    logic       fire;       // input register moves through the compute pass
    logic       s_accept;
    mlr_state_t load_state, step_state;
    logic       last;

    assign out_free = ~m_valid_reg | m_ready;
    assign fire     = in_valid_reg & out_free;
    assign s_ready  = ~in_valid_reg | out_free;
    assign s_accept = s_valid & s_ready;

    mlr_setup u_setup (
        .cmd_in     (in_data_reg),
        .load_state (load_state)
    );

    mlr_step u_step (
        .cur_state  (state_reg),
        .next_state (step_state)
    );

    always_comb begin
        state_next    = state_reg;
        out_data_next = '0;
        last          = 1'b0;
        if (in_data_reg.command == CMD_LOAD) begin
            last                      = at_end(load_state);
            state_next                = load_state;
            state_next.active         = ~last;
            out_data_next.pixel_x     = load_state.cur_x;
            out_data_next.pixel_y     = load_state.cur_y;
            out_data_next.pixel_valid = 1'b1;
            out_data_next.last_pixel  = last;
        end else if (state_reg.active) begin
            last                      = at_end(step_state);
            state_next                = step_state;
            state_next.active         = ~last;
            out_data_next.pixel_x     = step_state.cur_x;
            out_data_next.pixel_y     = step_state.cur_y;
            out_data_next.pixel_valid = 1'b1;
            out_data_next.last_pixel  = last;
        end
    end

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_accept) begin
            in_valid_next = 1'b1;
        end else if (fire) begin
            in_valid_next = 1'b0;
        end
        m_valid_next = m_valid_reg;
        if (fire) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            state_reg    <= '0;
        end else begin
            in_valid_reg <= in_valid_next;
            m_valid_reg  <= m_valid_next;
            if (fire) begin
                state_reg <= state_next;
            end
        end
    end

    // Payload registers, no reset
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_data_reg <= s_payload;
        end
        if (fire) begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = out_data_reg;

`ifndef SYNTHESIS
    // Reset leaves no result pending.
    a_reset_clears_out: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // An idle result carries zero coordinates and no last flag.
    a_idle_result_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_payload.pixel_valid) |->
            (m_payload.pixel_x == '0) && (m_payload.pixel_y == '0) && !m_payload.last_pixel)
        else $error("idle result with nonzero fields");

    // Delivering the final pixel retires the line.
    a_last_retires: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && out_data_next.last_pixel) |=> !state_reg.active)
        else $error("line still active after last pixel");

    // A held input beat is not overwritten while the result side is full.
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !out_free) |=> (in_valid_reg && $stable(in_data_reg)))
        else $error("input register lost a beat");

    // Each compute pass lands in the result register.
    a_fire_to_out: assert property (@(posedge aclk) disable iff (!aresetn)
        fire |=> m_valid)
        else $error("compute pass did not produce a result");
`endif

endmodule
`default_nettype wire

FILE: rtl/core/mlr_setup.sv
// Load path: endpoint ordering, delta computation, mode pick and initial decision.
`default_nettype none
module mlr_setup
    import mlr_pkg::*;
(
    input  wire mlr_in_t cmd_in,
    output mlr_state_t   load_state
);

    coord_t x1, y1, x2, y2;
    logic   swap;
    logic [COORD_BITS-1:0]      dx;
    logic signed [COORD_BITS:0] dy;
    dec_t   dxs, dys;

    assign swap = (cmd_in.start_x > cmd_in.end_x)
               || ((cmd_in.start_x == cmd_in.end_x) && (cmd_in.start_y > cmd_in.end_y));

    assign x1 = swap ? cmd_in.end_x   : cmd_in.start_x;
    assign y1 = swap ? cmd_in.end_y   : cmd_in.start_y;
    assign x2 = swap ? cmd_in.start_x : cmd_in.end_x;
    assign y2 = swap ? cmd_in.start_y : cmd_in.end_y;

    assign dx  = x2 - x1;
    assign dy  = $signed({1'b0, y2}) - $signed({1'b0, y1});
    assign dxs = $signed({{(DEC_W-COORD_BITS){1'b0}}, dx});
    assign dys = {{(DEC_W-COORD_BITS-1){dy[COORD_BITS]}}, dy};

    always_comb begin
        load_state          = '0;
        load_state.cur_x    = x1;
        load_state.cur_y    = y1;
        load_state.stop_x   = x2;
        load_state.stop_y   = y2;
        load_state.delta_x  = dx;
        load_state.delta_y  = dy;
        load_state.active   = 1'b1;
        if (dx == '0) begin
            load_state.mode = MODE_VERT;
        end else if (dy == '0) begin
            load_state.mode = MODE_HORIZ;
        end else if (dys == dxs) begin
            load_state.mode = MODE_DIAG_POS;
        end else if (dys == -dxs) begin
            load_state.mode = MODE_DIAG_NEG;
        end else if ((dys > 0) && (dys < dxs)) begin
            load_state.mode     = MODE_SHALLOW_POS;
            load_state.decision = (dys <<< 1) - dxs;
        end else if (dys > dxs) begin
            load_state.mode     = MODE_STEEP_POS;
            load_state.decision = dys - (dxs <<< 1);
        end else if ((dys < 0) && (-dys < dxs)) begin
            load_state.mode     = MODE_SHALLOW_NEG;
            load_state.decision = (dys <<< 1) + dxs;
        end else begin
            load_state.mode     = MODE_STEEP_NEG;
            load_state.decision = dys + (dxs <<< 1);
        end
    end

endmodule
`default_nettype wire

FILE: rtl/core/mlr_step.sv
// Step path: one midpoint advance of the current pixel and decision term.
`default_nettype none
module mlr_step
    import mlr_pkg::*;
(
    input  wire mlr_state_t cur_state,
    output mlr_state_t      next_state
);

    dec_t a_term, dxs, twice_a, twice_sum, twice_diff, twice_dx;
    logic dec_nonneg;

    assign a_term     = {{(DEC_W-COORD_BITS-1){cur_state.delta_y[COORD_BITS]}},
                         cur_state.delta_y};
    assign dxs        = $signed({{(DEC_W-COORD_BITS){1'b0}}, cur_state.delta_x});
    assign twice_a    = a_term <<< 1;
    assign twice_dx   = dxs <<< 1;
    assign twice_sum  = (a_term - dxs) <<< 1;   // 2*(a+b), b = -dx
    assign twice_diff = (a_term + dxs) <<< 1;   // 2*(a-b)
    assign dec_nonneg = ~cur_state.decision[DEC_W-1];

    always_comb begin
        next_state = cur_state;
        case (cur_state.mode)
            MODE_VERT: begin
                next_state.cur_y = cur_state.cur_y + 1'b1;
            end
            MODE_HORIZ: begin
                next_state.cur_x = cur_state.cur_x + 1'b1;
            end
            MODE_DIAG_POS: begin
                next_state.cur_x = cur_state.cur_x + 1'b1;
                next_state.cur_y = cur_state.cur_y + 1'b1;
            end
            MODE_DIAG_NEG: begin
                next_state.cur_x = cur_state.cur_x + 1'b1;
                next_state.cur_y = cur_state.cur_y - 1'b1;
            end
            MODE_SHALLOW_POS: begin
                next_state.cur_x = cur_state.cur_x + 1'b1;
                if (dec_nonneg) begin
                    next_state.decision = cur_state.decision + twice_sum;
                    next_state.cur_y    = cur_state.cur_y + 1'b1;
                end else begin
                    next_state.decision = cur_state.decision + twice_a;
                end
            end
            MODE_STEEP_POS: begin
                next_state.cur_y = cur_state.cur_y + 1'b1;
                if (dec_nonneg) begin
                    next_state.decision = cur_state.decision - twice_dx;
                end else begin
                    next_state.decision = cur_state.decision + twice_sum;
                    next_state.cur_x    = cur_state.cur_x + 1'b1;
                end
            end
            MODE_SHALLOW_NEG: begin
                next_state.cur_x = cur_state.cur_x + 1'b1;
                if (dec_nonneg) begin
                    next_state.decision = cur_state.decision + twice_a;
                end else begin
                    next_state.decision = cur_state.decision + twice_diff;
                    next_state.cur_y    = cur_state.cur_y - 1'b1;
                end
            end
            default: begin
                // steep negative
                next_state.cur_y = cur_state.cur_y - 1'b1;
                if (dec_nonneg) begin
                    next_state.decision = cur_state.decision + twice_diff;
                    next_state.cur_x    = cur_state.cur_x + 1'b1;
                end else begin
                    next_state.decision = cur_state.decision + twice_dx;
                end
            end
        endcase
    end

endmodule
`default_nettype wire

FILE: sim/pixel_checker.sv
`timescale 1ns / 100ps
// Line rasterizer checker: follows both channels, predicts every result beat and compares.
module pixel_checker
    import mlr_pkg::*;
(
    input  wire      aclk,
    input  wire      aresetn,
    input  wire      s_valid,
    input  wire      s_ready,
    input  mlr_in_t  s_payload,
    input  wire      m_valid,
    input  wire      m_ready,
    input  mlr_out_t m_payload,
    output int       fail_count,
    output int       pending
);

    // Predicted walker: current pixel, far endpoint, deltas, error term, mode.
    coord_t   walk_x, walk_y, end_px, end_py;
    int       run_dx, rise_dy, err_term;
    mode_t    walk_mode;
    logic     line_live;
    mlr_out_t pixel_queue[$];

    // y-major lines finish on y, the rest on x
    function automatic logic walk_done();
        if (walk_mode == MODE_VERT || walk_mode == MODE_STEEP_POS
                || walk_mode == MODE_STEEP_NEG) begin
            return walk_y == end_py;
        end
        return walk_x == end_px;
    endfunction

    function automatic mlr_out_t trace_pixel(input mlr_in_t beat);
        coord_t   x1, y1, x2, y2, t;
        int       a, b;
        logic     done;
        mlr_out_t res;
        res = '0;
        if (beat.command == CMD_LOAD) begin
            x1 = beat.start_x;
            y1 = beat.start_y;
            x2 = beat.end_x;
            y2 = beat.end_y;
            if (x1 > x2 || (x1 == x2 && y1 > y2)) begin
                t = x1; x1 = x2; x2 = t;
                t = y1; y1 = y2; y2 = t;
            end
            walk_x   = x1;
            walk_y   = y1;
            end_px   = x2;
            end_py   = y2;
            run_dx   = int'(x2) - int'(x1);
            rise_dy  = int'(y2) - int'(y1);
            err_term = 0;
            if (run_dx == 0) begin
                walk_mode = MODE_VERT;
            end else if (rise_dy == 0) begin
                walk_mode = MODE_HORIZ;
            end else if (rise_dy == run_dx) begin
                walk_mode = MODE_DIAG_POS;
            end else if (rise_dy == -run_dx) begin
                walk_mode = MODE_DIAG_NEG;
            end else if (rise_dy > 0 && rise_dy < run_dx) begin
                walk_mode = MODE_SHALLOW_POS;
                err_term  = 2 * rise_dy - run_dx;
            end else if (rise_dy > run_dx) begin
                walk_mode = MODE_STEEP_POS;
                err_term  = rise_dy - 2 * run_dx;
            end else if (rise_dy < 0 && -rise_dy < run_dx) begin
                walk_mode = MODE_SHALLOW_NEG;
                err_term  = 2 * rise_dy + run_dx;
            end else begin
                walk_mode = MODE_STEEP_NEG;
                err_term  = rise_dy + 2 * run_dx;
            end
            done      = walk_done();
            line_live = !done;
        end else begin
            if (!line_live) begin
                return res;
            end
            a = rise_dy;
            b = -run_dx;
            case (walk_mode)
                MODE_VERT: begin
                    walk_y++;
                end
                MODE_HORIZ: begin
                    walk_x++;
                end
                MODE_DIAG_POS: begin
                    walk_x++;
                    walk_y++;
                end
                MODE_DIAG_NEG: begin
                    walk_x++;
                    walk_y--;
                end
                MODE_SHALLOW_POS: begin
                    walk_x++;
                    if (err_term >= 0) begin
                        err_term += 2 * (a + b);
                        walk_y++;
                    end else begin
                        err_term += 2 * a;
                    end
                end
                MODE_STEEP_POS: begin
                    walk_y++;
                    if (err_term >= 0) begin
                        err_term += 2 * b;
                    end else begin
                        err_term += 2 * (a + b);
                        walk_x++;
                    end
                end
                MODE_SHALLOW_NEG: begin
                    walk_x++;
                    if (err_term >= 0) begin
                        err_term += 2 * a;
                    end else begin
                        err_term += 2 * (a - b);
                        walk_y--;
                    end
                end
                default: begin
                    walk_y--;
                    if (err_term >= 0) begin
                        err_term += 2 * (a - b);
                        walk_x++;
                    end else begin
                        err_term -= 2 * b;
                    end
                end
            endcase
            done = walk_done();
            if (done) begin
                line_live = 1'b0;
            end
        end
        res.pixel_x     = walk_x;
        res.pixel_y     = walk_y;
        res.pixel_valid = 1'b1;
        res.last_pixel  = done;
        return res;
    endfunction

    always @(posedge aclk) begin : watch
        mlr_out_t want;
        int       errs;
        errs = 0;
        if (!aresetn) begin
            walk_x    = '0;
            walk_y    = '0;
            end_px    = '0;
            end_py    = '0;
            run_dx    = 0;
            rise_dy   = 0;
            err_term  = 0;
            walk_mode = MODE_VERT;
            line_live = 1'b0;
            pixel_queue.delete();
        end else begin
            // input first: a result can never precede its own beat
            if (s_valid && s_ready) begin
                pixel_queue = {pixel_queue, trace_pixel(s_payload)};
            end
            if (m_valid && m_ready) begin
                if (pixel_queue.size() == 0) begin
                    $display("%0t: unexpected result beat x=%0d y=%0d valid=%0b last=%0b",
                             $time, m_payload.pixel_x, m_payload.pixel_y,
                             m_payload.pixel_valid, m_payload.last_pixel);
                    errs++;
                end else begin
                    want = pixel_queue.pop_front();
                    if (m_payload.pixel_x !== want.pixel_x) begin
                        $display("%0t: pixel_x expected %0d actual %0d",
                                 $time, want.pixel_x, m_payload.pixel_x);
                        errs++;
                    end
                    if (m_payload.pixel_y !== want.pixel_y) begin
                        $display("%0t: pixel_y expected %0d actual %0d",
                                 $time, want.pixel_y, m_payload.pixel_y);
                        errs++;
                    end
                    if (m_payload.pixel_valid !== want.pixel_valid) begin
                        $display("%0t: pixel_valid expected %0b actual %0b",
                                 $time, want.pixel_valid, m_payload.pixel_valid);
                        errs++;
                    end
                    if (m_payload.last_pixel !== want.last_pixel) begin
                        $display("%0t: last_pixel expected %0b actual %0b",
                                 $time, want.last_pixel, m_payload.last_pixel);
                        errs++;
                    end
                end
            end
        end
        fail_count <= fail_count + errs;
        pending    <= pixel_queue.size();
    end

endmodule

FILE: sim/tb.sv
`timescale 1ns / 100ps
// Testbench top for the line rasterizer: clock, reset, beat stimulus, stalls and verdict.
module tb;
    import mlr_pkg::*;

    logic     aclk      = 1'b0;
    logic     aresetn   = 1'b0;
    logic     s_valid   = 1'b0;
    mlr_in_t  s_payload = '0;
    logic     m_ready   = 1'b0;
    logic     s_ready;
    logic     m_valid;
    mlr_out_t m_payload;

    int       fail_count;
    int       pending;

    // idle_on gates random gaps on both sides; off for the tail of the run
    logic     idle_on    = 1'b0;
    int       stall_left = 0;
    int       beats_sent = 0;

    always #5 aclk = ~aclk;

    midpoint_line_rasterizer_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

    pixel_checker pixel_chk (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_payload  (s_payload),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_payload  (m_payload),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // Result side back-pressure: random stall bursts while idle_on is set.
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_ready    <= 1'b0;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(1, 10) - 1;
            m_ready    <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Present one beat, optionally after an idle burst, and hold it until taken.
    // Valid is never dropped between back-to-back beats, so each time step
    // sees at most one update of s_valid.
    task automatic send_beat(input mlr_in_t beat);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 10);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_payload <= beat;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        beats_sent++;
    endtask

    // Step beat; the coordinate fields are ignored by the block, so fill them
    // with noise to toggle every input bit.
    function automatic mlr_in_t step_beat();
        mlr_in_t beat;
        beat.command = CMD_STEP;
        beat.start_x = coord_t'($urandom);
        beat.start_y = coord_t'($urandom);
        beat.end_x   = coord_t'($urandom);
        beat.end_y   = coord_t'($urandom);
        return beat;
    endfunction

    // Load a line, then walk it for nsteps step beats.
    task automatic draw_line(input coord_t x1, input coord_t y1,
                             input coord_t x2, input coord_t y2, input int nsteps);
        mlr_in_t beat;
        int      i;
        beat.command = CMD_LOAD;
        beat.start_x = x1;
        beat.start_y = y1;
        beat.end_x   = x2;
        beat.end_y   = y2;
        send_beat(beat);
        for (i = 0; i < nsteps; i++) begin
            send_beat(step_beat());
        end
    endtask

    // Hold the input quiet until every predicted pixel has come back.
    task automatic drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
    endtask

    initial begin : stimulus
        int      dx, dy, x0, y0, n, r, k;
        logic    mid_drained;
        mlr_in_t beat;
        mid_drained = 1'b0;

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        idle_on <= 1'b1;
        @(posedge aclk);

        // ---- directed part ----
        // step before any line was loaded: invalid pixel
        send_beat(step_beat());
        // single point line, then a step that finds nothing active
        draw_line(5, 5, 5, 5, 1);
        // vertical, given top-down so the block has to reorder by y
        draw_line(3, 7, 3, 4, 3);
        // horizontal at the right edge of the coordinate range, reversed
        draw_line(1023, 0, 1021, 0, 2);
        // both diagonals, the second one touching x = 1023
        draw_line(0, 0, 1, 1, 1);
        draw_line(1023, 0, 1022, 1, 1);
        // shallow positive walked to its end
        draw_line(0, 0, 3, 1, 3);
        // steep positive, cut short by the next load
        draw_line(0, 0, 1, 3, 1);
        // shallow and steep negative slopes
        draw_line(0, 1, 3, 0, 1);
        draw_line(0, 3, 1, 0, 1);
        // full-range diagonal loaded from the far corner, then interrupted
        draw_line(1023, 1023, 0, 0, 1);
        drain();

        // ---- random part ----
        while (beats_sent < 1000) begin
            // last stretch runs with no gaps at all; elsewhere gaps come and go
            if (beats_sent >= 880) begin
                idle_on <= 1'b0;
            end else begin
                idle_on <= ($urandom_range(0, 4) != 0);
            end
            // halfway through, let the pipeline run completely dry once
            if (!mid_drained && beats_sent >= 500) begin
                mid_drained = 1'b1;
                drain();
            end

            // short line: small deltas, random shape, anywhere on the grid
            dx = $urandom_range(0, 20);
            dy = $urandom_range(0, 20);
            if ($urandom_range(0, 1)) begin
                dy = -dy;
            end
            case ($urandom_range(0, 9))
                0: dx = 0;
                1: dy = 0;
                2: dy = dx;
                3: dy = -dx;
                default: ;
            endcase
            x0 = $urandom_range(0, 1023 - dx);
            if (dy >= 0) begin
                y0 = $urandom_range(0, 1023 - dy);
            end else begin
                y0 = $urandom_range(-dy, 1023);
            end
            n = (dx > (dy < 0 ? -dy : dy)) ? dx : (dy < 0 ? -dy : dy);

            r = $urandom_range(0, 99);
            if (r < 75) begin
                // well-formed: walk the whole line, sometimes step past the end
                if ($urandom_range(0, 3) == 0) begin
                    n += $urandom_range(1, 2);
                end
                if ($urandom_range(0, 1)) begin
                    draw_line(coord_t'(x0 + dx), coord_t'(y0 + dy),
                              coord_t'(x0), coord_t'(y0), n);
                end else begin
                    draw_line(coord_t'(x0), coord_t'(y0),
                              coord_t'(x0 + dx), coord_t'(y0 + dy), n);
                end
            end else if (r < 85) begin
                // full-range endpoints, only the first stretch of pixels
                draw_line(coord_t'($urandom), coord_t'($urandom),
                          coord_t'($urandom), coord_t'($urandom),
                          $urandom_range(0, 30));
            end else if (r < 93) begin
                // broken: the next load lands while this line is still live
                draw_line(coord_t'(x0), coord_t'(y0),
                          coord_t'(x0 + dx), coord_t'(y0 + dy),
                          (n > 0) ? $urandom_range(0, n - 1) : 0);
            end else begin
                // noise: a few beats with random command and fields
                for (k = $urandom_range(1, 4); k > 0; k--) begin
                    beat = step_beat();
                    beat.command = $urandom_range(0, 1) ? CMD_STEP : CMD_LOAD;
                    send_beat(beat);
                end
            end
        end

        // ---- wind down ----
        drain();
        repeat (12) @(posedge aclk);
        if (fail_count == 0) begin
            $display("midpoint_line_rasterizer_top verification clean");
        end else begin
            $display("midpoint_line_rasterizer_top verification failed");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run (about 1100 beats with the
    // longest gaps and the longest stalls on each).
    initial begin
        #5_000_000;
        $display("midpoint_line_rasterizer_top verification failed");
        $finish;
    end

endmodule
